// ----- sv/dll_pkg.sv -----
// Shared types, constants and microcode ROM for the array doubly linked list.
`default_nettype none

package dll_pkg;

   localparam int NODE_CAPACITY = 1024;
   localparam int SLOT_COUNT    = NODE_CAPACITY + 2;
   localparam int SLOT_W        = $clog2(SLOT_COUNT);
   localparam int NODE_W        = $clog2(NODE_CAPACITY);
   localparam int OP_W          = 3;
   localparam int POS_W         = 11;
   localparam int VAL_W         = 32;
   localparam int STAT_W        = 2;
   localparam int CMP_W         = (POS_W + 1 > SLOT_W) ? POS_W + 1 : SLOT_W;
   localparam int PC_W          = 5;

   localparam logic [SLOT_W-1:0] HEAD_SLOT  = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] TAIL_SLOT  = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(2);
   localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(SLOT_COUNT);

   // request opcodes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
   localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd3;
   localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_READ_NEXT  = 3'd6;

   // result status
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
   localparam logic [STAT_W-1:0] ST_REMOVED = 2'd3;

   // control word field codes
   localparam logic LSEL_TGT = 1'b0;
   localparam logic LSEL_CUR = 1'b1;

   localparam logic [2:0] AB_NONE   = 3'd0;
   localparam logic [2:0] AB_FRONT  = 3'd1;
   localparam logic [2:0] AB_BACK   = 3'd2;
   localparam logic [2:0] AB_BEFORE = 3'd3;
   localparam logic [2:0] AB_AFTER  = 3'd4;
   localparam logic [2:0] AB_REMOVE = 3'd5;

   localparam logic [1:0] WR_NONE   = 2'd0;
   localparam logic [1:0] WR_NEW1   = 2'd1;
   localparam logic [1:0] WR_NEW2   = 2'd2;
   localparam logic [1:0] WR_UNLINK = 2'd3;

   localparam logic [1:0] CUR_NONE  = 2'd0;
   localparam logic [1:0] CUR_FIRST = 2'd1;
   localparam logic [1:0] CUR_NEXT  = 2'd2;

   localparam logic [1:0] CHK_NONE   = 2'd0;
   localparam logic [1:0] CHK_FULL   = 2'd1;
   localparam logic [1:0] CHK_TGT    = 2'd2;
   localparam logic [1:0] CHK_TGT_RM = 2'd3;

   localparam logic RSP_NONE = 1'b0;
   localparam logic RSP_READ = 1'b1;

   // microcode step addresses
   localparam logic [PC_W-1:0] PC_FRONT  = 5'd0;
   localparam logic [PC_W-1:0] PC_BACK   = 5'd1;
   localparam logic [PC_W-1:0] PC_NEW1   = 5'd2;
   localparam logic [PC_W-1:0] PC_NEW2   = 5'd3;
   localparam logic [PC_W-1:0] PC_RM0    = 5'd4;
   localparam logic [PC_W-1:0] PC_RM1    = 5'd5;
   localparam logic [PC_W-1:0] PC_RM2    = 5'd6;
   localparam logic [PC_W-1:0] PC_IB0    = 5'd7;
   localparam logic [PC_W-1:0] PC_IB1    = 5'd8;
   localparam logic [PC_W-1:0] PC_IA0    = 5'd9;
   localparam logic [PC_W-1:0] PC_IA1    = 5'd10;
   localparam logic [PC_W-1:0] PC_FIRST  = 5'd11;
   localparam logic [PC_W-1:0] PC_NEXT0  = 5'd12;
   localparam logic [PC_W-1:0] PC_NEXT1  = 5'd13;
   localparam logic [PC_W-1:0] PC_VAL0   = 5'd14;
   localparam logic [PC_W-1:0] PC_VAL1   = 5'd15;
   localparam logic [PC_W-1:0] PC_NOP    = 5'd16;

   typedef struct packed {
      logic            lsel;
      logic [2:0]      ab;
      logic [1:0]      wr;
      logic [1:0]      cur;
      logic [1:0]      chk;
      logic            rsp;
      logic            fin;
      logic [PC_W-1:0] nxt;
   } ctrl_type;

   typedef struct packed {
      logic go;    // step may take effect this cycle
      logic done;  // step ends the request
   } step_type;

   function automatic ctrl_type uword(logic lsel, logic [2:0] ab, logic [1:0] wr,
                                      logic [1:0] cur, logic [1:0] chk, logic rsp,
                                      logic fin, logic [PC_W-1:0] nxt);
      ctrl_type w;
      w.lsel = lsel;
      w.ab   = ab;
      w.wr   = wr;
      w.cur  = cur;
      w.chk  = chk;
      w.rsp  = rsp;
      w.fin  = fin;
      w.nxt  = nxt;
      return w;
   endfunction

   function automatic ctrl_type ucode(logic [PC_W-1:0] pc);
      case (pc)
         PC_FRONT: return uword(LSEL_TGT, AB_FRONT,  WR_NONE,   CUR_NONE,  CHK_FULL,
                                RSP_NONE, 1'b0, PC_NEW1);
         PC_BACK:  return uword(LSEL_TGT, AB_BACK,   WR_NONE,   CUR_NONE,  CHK_FULL,
                                RSP_NONE, 1'b0, PC_NEW1);
         PC_NEW1:  return uword(LSEL_TGT, AB_NONE,   WR_NEW1,   CUR_NONE,  CHK_NONE,
                                RSP_NONE, 1'b0, PC_NEW2);
         PC_NEW2:  return uword(LSEL_TGT, AB_NONE,   WR_NEW2,   CUR_NONE,  CHK_NONE,
                                RSP_NONE, 1'b1, PC_NOP);
         PC_RM0:   return uword(LSEL_TGT, AB_NONE,   WR_NONE,   CUR_NONE,  CHK_NONE,
                                RSP_NONE, 1'b0, PC_RM1);
         PC_RM1:   return uword(LSEL_TGT, AB_REMOVE, WR_NONE,   CUR_NONE,  CHK_TGT_RM,
                                RSP_NONE, 1'b0, PC_RM2);
         PC_RM2:   return uword(LSEL_TGT, AB_NONE,   WR_UNLINK, CUR_NONE,  CHK_NONE,
                                RSP_NONE, 1'b1, PC_NOP);
         PC_IB0:   return uword(LSEL_TGT, AB_NONE,   WR_NONE,   CUR_NONE,  CHK_NONE,
                                RSP_NONE, 1'b0, PC_IB1);
         PC_IB1:   return uword(LSEL_TGT, AB_BEFORE, WR_NONE,   CUR_NONE,  CHK_TGT,
                                RSP_NONE, 1'b0, PC_NEW1);
         PC_IA0:   return uword(LSEL_TGT, AB_NONE,   WR_NONE,   CUR_NONE,  CHK_NONE,
                                RSP_NONE, 1'b0, PC_IA1);
         PC_IA1:   return uword(LSEL_TGT, AB_AFTER,  WR_NONE,   CUR_NONE,  CHK_TGT,
                                RSP_NONE, 1'b0, PC_NEW1);
         PC_FIRST: return uword(LSEL_TGT, AB_NONE,   WR_NONE,   CUR_FIRST, CHK_NONE,
                                RSP_NONE, 1'b0, PC_VAL0);
         PC_NEXT0: return uword(LSEL_CUR, AB_NONE,   WR_NONE,   CUR_NONE,  CHK_NONE,
                                RSP_NONE, 1'b0, PC_NEXT1);
         PC_NEXT1: return uword(LSEL_CUR, AB_NONE,   WR_NONE,   CUR_NEXT,  CHK_NONE,
                                RSP_NONE, 1'b0, PC_VAL0);
         PC_VAL0:  return uword(LSEL_TGT, AB_NONE,   WR_NONE,   CUR_NONE,  CHK_NONE,
                                RSP_NONE, 1'b0, PC_VAL1);
         PC_VAL1:  return uword(LSEL_TGT, AB_NONE,   WR_NONE,   CUR_NONE,  CHK_NONE,
                                RSP_READ, 1'b1, PC_NOP);
         default:  return uword(LSEL_TGT, AB_NONE,   WR_NONE,   CUR_NONE,  CHK_NONE,
                                RSP_NONE, 1'b1, PC_NOP);
      endcase
   endfunction

   function automatic logic [PC_W-1:0] entry(logic [OP_W-1:0] op);
      case (op)
         OP_PUSH_FRONT: return PC_FRONT;
         OP_PUSH_BACK:  return PC_BACK;
         OP_REMOVE:     return PC_RM0;
         OP_INS_BEFORE: return PC_IB0;
         OP_INS_AFTER:  return PC_IA0;
         OP_READ_FIRST: return PC_FIRST;
         OP_READ_NEXT:  return PC_NEXT0;
         default:       return PC_NOP;
      endcase
   endfunction

   // node memory index of a slot (slots 0 and 1 are the sentinels)
   function automatic logic [NODE_W-1:0] node_idx(logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] diff;
      diff = slot - FIRST_SLOT;
      return diff[NODE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- sv/dll_seq.sv -----
// Microcode sequencer: step counter, dispatch and control ROM.
`default_nettype none

module dll_seq
   import dll_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [OP_W-1:0] start_op,
   input  wire step_type        step,
   output ctrl_type             ctrl,
   output logic                 busy
);

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            busy_ff, busy_in;

   assign ctrl = ucode(pc_ff);
   assign busy = busy_ff;

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         pc_in   = entry(start_op);
         busy_in = 1'b1;
      end else if (busy_ff && step.go) begin
         if (step.done) begin
            busy_in = 1'b0;
         end else begin
            pc_in = ctrl.nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PC_NOP;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/array_doubly_linked_list_unit.sv -----
// Array doubly linked list: request latch, node memories, link datapath, result register.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_ready  | op, position, value
//   rsp     | out       | rsp_valid/rsp_ready  | status, read_valid, read_value
//
// Steps per request: push, remove, read first 3; insert, read next 4; a full list or bad
// target ends at its check step after 1 or 2, an unknown op after 1. After its last step the
// unit goes idle before it takes the next beat; the registered read port of each link memory
// and the two link writes set the steps. Reset clears control state and sentinel links; node
// memories are not cleared, the next-free-slot register tells which entries hold data.
// A new request is taken while a result waits; its last step holds while that result waits.
`default_nettype none

module array_doubly_linked_list_unit
   import dll_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic signed [VAL_W-1:0] req_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [STAT_W-1:0]      rsp_status,
   output logic                   rsp_read_valid,
   output logic signed [VAL_W-1:0] rsp_read_value
);

   ctrl_type ctrl;
   step_type step;
   logic     busy;
   logic     start;

   // request registers
   logic [POS_W:0]      kp_ff;     // position + 1, the target slot
   logic [VAL_W-1:0]    value_ff;

   // list state
   logic [SLOT_W-1:0]   nfs_ff;
   logic [SLOT_W-1:0]   cursor_ff, cursor_in;
   logic [SLOT_W-1:0]   head_right_ff, head_right_in;
   logic [SLOT_W-1:0]   tail_left_ff, tail_left_in;
   logic [SLOT_W-1:0]   a_ff, a_in;
   logic [SLOT_W-1:0]   b_ff, b_in;

   // node memories
   logic [SLOT_W-1:0]   left_mem  [SLOT_COUNT];
   logic [SLOT_W-1:0]   right_mem [SLOT_COUNT];
   logic [VAL_W-1:0]    val_mem   [NODE_CAPACITY];
   logic                alive_mem [NODE_CAPACITY];

   logic [SLOT_W-1:0]   left_rd_ff, right_rd_ff, link_raddr_ff;
   logic [VAL_W-1:0]    val_rd_ff;
   logic                alive_rd_ff;

   // result register
   logic                rsp_valid_ff;
   logic [STAT_W-1:0]   rsp_status_ff;
   logic                rsp_read_valid_ff;
   logic [VAL_W-1:0]    rsp_read_value_ff;

   logic [SLOT_W-1:0]   tgt;
   logic [SLOT_W-1:0]   link_raddr;
   logic [SLOT_W-1:0]   lrd, rrd;
   logic                full, range_err, act;
   logic [STAT_W-1:0]   fail_code;
   logic                read_ok;

   logic                lw_en, rw_en, vw_en, aw_en, aw_data;
   logic [SLOT_W-1:0]   lw_addr, lw_data, rw_addr, rw_data;
   logic [NODE_W-1:0]   aw_addr;

   assign req_ready = !busy && !reset;
   assign start     = req_valid && req_ready;

   dll_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .start_op (req_op),
      .step     (step),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   always_ff @(posedge clock) begin
      if (start) begin
         kp_ff    <= {1'b0, req_position} + (POS_W+1)'(1);
         value_ff <= req_value;
      end
   end

   assign tgt        = kp_ff[SLOT_W-1:0];
   assign link_raddr = (ctrl.lsel == LSEL_CUR) ? cursor_ff : tgt;

   // sentinel links live in registers; head.left and tail.right never change
   assign lrd = (link_raddr_ff == HEAD_SLOT) ? HEAD_SLOT :
                (link_raddr_ff == TAIL_SLOT) ? tail_left_ff : left_rd_ff;
   assign rrd = (link_raddr_ff == HEAD_SLOT) ? head_right_ff :
                (link_raddr_ff == TAIL_SLOT) ? TAIL_SLOT : right_rd_ff;

   assign full      = nfs_ff >= SLOT_LIMIT;
   assign range_err = (kp_ff == (POS_W+1)'(1)) || (CMP_W'(kp_ff) >= CMP_W'(nfs_ff));

   always_comb begin
      case (ctrl.chk)
         CHK_NONE:   fail_code = ST_OK;
         CHK_FULL:   fail_code = full ? ST_FULL : ST_OK;
         CHK_TGT:    fail_code = range_err ? ST_RANGE :
                                 !alive_rd_ff ? ST_REMOVED :
                                 full ? ST_FULL : ST_OK;
         CHK_TGT_RM: fail_code = range_err ? ST_RANGE :
                                 !alive_rd_ff ? ST_REMOVED : ST_OK;
         default:    fail_code = ST_OK;
      endcase
   end

   always_comb begin
      step.done = ctrl.fin || (fail_code != ST_OK);
      step.go   = !(step.done && rsp_valid_ff && !rsp_ready);
   end

   assign act = busy && step.go && (fail_code == ST_OK);

   // neighbor registers and cursor
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      case (ctrl.ab)
         AB_FRONT:  begin a_in = HEAD_SLOT;    b_in = head_right_ff; end
         AB_BACK:   begin a_in = tail_left_ff; b_in = TAIL_SLOT;     end
         AB_BEFORE: begin a_in = lrd;          b_in = tgt;           end
         AB_AFTER:  begin a_in = tgt;          b_in = rrd;           end
         AB_REMOVE: begin a_in = lrd;          b_in = rrd;           end
         default:   ;
      endcase
      cursor_in = cursor_ff;
      case (ctrl.cur)
         CUR_FIRST: cursor_in = head_right_ff;
         CUR_NEXT:  if (cursor_ff != TAIL_SLOT) cursor_in = rrd;
         default:   ;
      endcase
   end

   // memory write ports, one per memory
   always_comb begin
      lw_en = 1'b0; lw_addr = nfs_ff; lw_data = a_ff;
      rw_en = 1'b0; rw_addr = nfs_ff; rw_data = b_ff;
      vw_en = 1'b0;
      aw_en = 1'b0; aw_addr = node_idx(nfs_ff); aw_data = 1'b1;
      head_right_in = head_right_ff;
      tail_left_in  = tail_left_ff;
      if (act) begin
         case (ctrl.wr)
            WR_NEW1: begin
               lw_en = 1'b1;
               rw_en = 1'b1;
               vw_en = 1'b1;
               aw_en = 1'b1;
            end
            WR_NEW2: begin
               if (a_ff == HEAD_SLOT) head_right_in = nfs_ff;
               else begin rw_en = 1'b1; rw_addr = a_ff; rw_data = nfs_ff; end
               if (b_ff == TAIL_SLOT) tail_left_in = nfs_ff;
               else begin lw_en = 1'b1; lw_addr = b_ff; lw_data = nfs_ff; end
            end
            WR_UNLINK: begin
               if (a_ff == HEAD_SLOT) head_right_in = b_ff;
               else begin rw_en = 1'b1; rw_addr = a_ff; rw_data = b_ff; end
               if (b_ff == TAIL_SLOT) tail_left_in = a_ff;
               else begin lw_en = 1'b1; lw_addr = b_ff; lw_data = a_ff; end
               aw_en   = 1'b1;
               aw_addr = node_idx(tgt);
               aw_data = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (lw_en) left_mem[lw_addr] <= lw_data;
      left_rd_ff <= left_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (rw_en) right_mem[rw_addr] <= rw_data;
      right_rd_ff <= right_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (vw_en) val_mem[node_idx(nfs_ff)] <= value_ff;
      val_rd_ff <= val_mem[node_idx(cursor_ff)];
   end

   always_ff @(posedge clock) begin
      if (aw_en) alive_mem[aw_addr] <= aw_data;
      alive_rd_ff <= alive_mem[node_idx(tgt)];
   end

   always_ff @(posedge clock) begin
      link_raddr_ff <= link_raddr;
      if (act) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign read_ok = (ctrl.rsp == RSP_READ) && (cursor_ff >= FIRST_SLOT);

   always_ff @(posedge clock) begin
      if (reset) begin
         nfs_ff        <= FIRST_SLOT;
         cursor_ff     <= HEAD_SLOT;
         head_right_ff <= TAIL_SLOT;
         tail_left_ff  <= HEAD_SLOT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (act) begin
            cursor_ff     <= cursor_in;
            head_right_ff <= head_right_in;
            tail_left_ff  <= tail_left_in;
            if (ctrl.wr == WR_NEW2) nfs_ff <= nfs_ff + SLOT_W'(1);
         end
         if (busy && step.go && step.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy && step.go && step.done) begin
         rsp_status_ff     <= fail_code;
         rsp_read_valid_ff <= read_ok;
         rsp_read_value_ff <= read_ok ? val_rd_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_valid = rsp_read_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule

`default_nettype wire

// ----- sv/dll_checker.sv -----
// Port-level checks for the array doubly linked list, bound to the top level.
`default_nettype none

module dll_checker
   import dll_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [STAT_W-1:0] rsp_status,
   input wire logic              rsp_read_valid,
   input wire logic [VAL_W-1:0]  rsp_read_value
);

   // a waiting result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_read_valid) && $stable(rsp_read_value))
      else $error("rsp beat changed while stalled");

   // a request keeps the unit busy for at least the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   // errors never return data
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_read_valid)
      else $error("read_valid set on error status");

   a_no_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_value == '0)
      else $error("read_value nonzero without read_valid");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

endmodule

bind array_doubly_linked_list_unit dll_checker u_dll_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_read_valid (rsp_read_valid),
   .rsp_read_value (rsp_read_value)
);

`default_nettype wire
